// ===== rtl/core/spct_pkg.sv =====
// Shared constants for the shape pair collision test.
package spct_pkg;

   localparam int POINT_W        = 63;  // packed x, y, z coordinate word
   localparam int RADIUS_W       = 20;  // radius port width
   localparam int COORD_BITS_DEF = 21;  // default signed coordinate width

   // Shape kind codes
   localparam logic KIND_SPHERE = 1'b0;
   localparam logic KIND_BOX    = 1'b1;

endpackage

// ===== rtl/core/shape_pair_collision_test.sv =====
// Pipelined narrow-phase hit test for one sphere/box pair per transaction.
//
// Accepts one transaction every clock cycle; busy is never raised. Each transaction produces one
// rsp_hit value with rsp_strobe high, in the order the transactions entered. The result
// passes through six register stages: operand selection and clamping,
// per-axis products, dot-product sums, split partial products of the wide segment test,
// their recombination, and the final compare. The receiver cannot hold results off, and
// the pipeline never stalls.
module shape_pair_collision_test #(
   parameter int COORD_BITS = spct_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_a_kind,
   input  logic                          req_b_kind,
   input  logic [1:0]                    req_swept_sel,
   input  logic [spct_pkg::POINT_W-1:0]  req_a_point,
   input  logic [spct_pkg::POINT_W-1:0]  req_a_corner,
   input  logic [spct_pkg::RADIUS_W-1:0] req_a_radius,
   input  logic [spct_pkg::POINT_W-1:0]  req_a_prev,
   input  logic [spct_pkg::POINT_W-1:0]  req_b_point,
   input  logic [spct_pkg::POINT_W-1:0]  req_b_corner,
   input  logic [spct_pkg::RADIUS_W-1:0] req_b_radius,
   input  logic [spct_pkg::POINT_W-1:0]  req_b_prev,
   output logic                          rsp_strobe,
   output logic                          rsp_hit
);

   localparam int CB  = COORD_BITS;
   localparam int DW  = CB + 1;          // coordinate difference
   localparam int PW  = 2 * DW;          // per-axis product
   localparam int SW  = PW + 2;          // signed three-term dot product
   localparam int MW  = SW - 1;          // magnitude fed to the wide multiplies
   localparam int LO  = (MW + 1) / 2;
   localparam int XW  = 2 * MW;          // wide product
   localparam int RSW = CB;              // radius sum
   localparam int RRW = 2 * CB;          // squared radius sum

   typedef logic signed [CB-1:0] crd_type [3];
   typedef logic signed [DW-1:0] dif_type [3];

   logic go;
   assign go   = start & ~busy;
   assign busy = 1'b0;

   // ---------------- stage 1: unpack, select, clamp ----------------
   crd_type ap, ac, apr, bp, bc, bpr;
   crd_type st, en, cc, bmin, bmax, sc;
   dif_type ab_in, ac_in, bc_in;
   logic [CB-2:0]  ar, br;
   logic [RSW-1:0] rs_in;
   logic           is_bb_in, bbhit_in, both_sph, sw_a, sw_b;
   logic signed [CB-1:0] clp;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ap[i]  = req_a_point[i*CB +: CB];
         ac[i]  = req_a_corner[i*CB +: CB];
         apr[i] = req_a_prev[i*CB +: CB];
         bp[i]  = req_b_point[i*CB +: CB];
         bc[i]  = req_b_corner[i*CB +: CB];
         bpr[i] = req_b_prev[i*CB +: CB];
      end
      ar = req_a_radius[CB-2:0];
      br = req_b_radius[CB-2:0];
      both_sph = (req_a_kind == spct_pkg::KIND_SPHERE) && (req_b_kind == spct_pkg::KIND_SPHERE);
      is_bb_in = (req_a_kind == spct_pkg::KIND_BOX) && (req_b_kind == spct_pkg::KIND_BOX);
      sw_a = req_swept_sel[0];
      sw_b = req_swept_sel[1] & ~req_swept_sel[0];
      bbhit_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (ap[i] > bc[i] || ac[i] < bp[i]) bbhit_in = 1'b0;
      end
      // plain sphere pair is a segment of zero length
      for (int i = 0; i < 3; i++) begin
         st[i] = sw_a ? apr[i] : (sw_b ? bpr[i] : ap[i]);
         en[i] = sw_b ? bp[i] : ap[i];
         cc[i] = sw_b ? ap[i] : bp[i];
         bmin[i] = (req_a_kind == spct_pkg::KIND_BOX) ? ap[i] : bp[i];
         bmax[i] = (req_a_kind == spct_pkg::KIND_BOX) ? ac[i] : bc[i];
         sc[i]   = (req_a_kind == spct_pkg::KIND_BOX) ? bp[i] : ap[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (sc[i] < bmin[i])      clp = bmin[i];
         else if (sc[i] > bmax[i]) clp = bmax[i];
         else                      clp = sc[i];
         if (both_sph) begin
            ab_in[i] = DW'(en[i]) - DW'(st[i]);
            ac_in[i] = DW'(cc[i]) - DW'(st[i]);
            bc_in[i] = DW'(cc[i]) - DW'(en[i]);
         end else begin
            // box-sphere: zero segment so only the near-end distance counts
            ab_in[i] = '0;
            ac_in[i] = DW'(sc[i]) - DW'(clp);
            bc_in[i] = '0;
         end
      end
      if (both_sph)
         rs_in = RSW'(ar) + RSW'(br);
      else if (req_a_kind == spct_pkg::KIND_BOX)
         rs_in = RSW'(br);
      else
         rs_in = RSW'(ar);
   end

   logic           v1_ff, is_bb1_ff, bbhit1_ff;
   dif_type        ab1_ff, ac1_ff, bc1_ff;
   logic [RSW-1:0] rs1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= go;
      ab1_ff <= ab_in;
      ac1_ff <= ac_in;
      bc1_ff <= bc_in;
      rs1_ff <= rs_in;
      is_bb1_ff <= is_bb_in;
      bbhit1_ff <= bbhit_in;
   end

   // ---------------- stage 2: per-axis products ----------------
   logic signed [PW-1:0] pe2_ff [3], pf2_ff [3], pa2_ff [3], pb2_ff [3];
   logic [RRW-1:0]       r22_ff;
   logic                 v2_ff, is_bb2_ff, bbhit2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      for (int i = 0; i < 3; i++) begin
         pe2_ff[i] <= ac1_ff[i] * ab1_ff[i];
         pf2_ff[i] <= ab1_ff[i] * ab1_ff[i];
         pa2_ff[i] <= ac1_ff[i] * ac1_ff[i];
         pb2_ff[i] <= bc1_ff[i] * bc1_ff[i];
      end
      r22_ff <= RRW'(rs1_ff) * RRW'(rs1_ff);
      is_bb2_ff <= is_bb1_ff;
      bbhit2_ff <= bbhit1_ff;
   end

   // ---------------- stage 3: dot-product sums ----------------
   logic signed [SW-1:0] e3_ff, f3_ff, a3_ff, b3_ff;
   logic [RRW-1:0]       r23_ff;
   logic                 v3_ff, is_bb3_ff, bbhit3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      e3_ff <= SW'(pe2_ff[0]) + SW'(pe2_ff[1]) + SW'(pe2_ff[2]);
      f3_ff <= SW'(pf2_ff[0]) + SW'(pf2_ff[1]) + SW'(pf2_ff[2]);
      a3_ff <= SW'(pa2_ff[0]) + SW'(pa2_ff[1]) + SW'(pa2_ff[2]);
      b3_ff <= SW'(pb2_ff[0]) + SW'(pb2_ff[1]) + SW'(pb2_ff[2]);
      r23_ff <= r22_ff;
      is_bb3_ff <= is_bb2_ff;
      bbhit3_ff <= bbhit2_ff;
   end

   // ---------------- stage 4: split partial products ----------------
   logic [MW-1:0] fm, am, em, rm;
   logic          near_in, far_in;

   always_comb begin
      fm = f3_ff[MW-1:0];
      am = a3_ff[MW-1:0];
      em = e3_ff[MW-1:0];
      rm = MW'(r23_ff);
      if (e3_ff <= 0) near_in = ($unsigned(a3_ff) <= SW'(r23_ff));
      else            near_in = ($unsigned(b3_ff) <= SW'(r23_ff));
      far_in = (e3_ff > 0) && (e3_ff < f3_ff);
   end

   // index: 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 hi*hi
   logic [2*LO-1:0] pfa4_ff [4], pfr4_ff [4], pee4_ff [4];
   logic            v4_ff, is_bb4_ff, bbhit4_ff, near4_ff, far4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      pfa4_ff[0] <= (2*LO)'(fm[LO-1:0]) * (2*LO)'(am[LO-1:0]);
      pfa4_ff[1] <= (2*LO)'(fm[LO-1:0]) * (2*LO)'(am[MW-1:LO]);
      pfa4_ff[2] <= (2*LO)'(fm[MW-1:LO]) * (2*LO)'(am[LO-1:0]);
      pfa4_ff[3] <= (2*LO)'(fm[MW-1:LO]) * (2*LO)'(am[MW-1:LO]);
      pfr4_ff[0] <= (2*LO)'(fm[LO-1:0]) * (2*LO)'(rm[LO-1:0]);
      pfr4_ff[1] <= (2*LO)'(fm[LO-1:0]) * (2*LO)'(rm[MW-1:LO]);
      pfr4_ff[2] <= (2*LO)'(fm[MW-1:LO]) * (2*LO)'(rm[LO-1:0]);
      pfr4_ff[3] <= (2*LO)'(fm[MW-1:LO]) * (2*LO)'(rm[MW-1:LO]);
      pee4_ff[0] <= (2*LO)'(em[LO-1:0]) * (2*LO)'(em[LO-1:0]);
      pee4_ff[1] <= (2*LO)'(em[LO-1:0]) * (2*LO)'(em[MW-1:LO]);
      pee4_ff[2] <= (2*LO)'(em[MW-1:LO]) * (2*LO)'(em[LO-1:0]);
      pee4_ff[3] <= (2*LO)'(em[MW-1:LO]) * (2*LO)'(em[MW-1:LO]);
      near4_ff  <= near_in;
      far4_ff   <= far_in;
      is_bb4_ff <= is_bb3_ff;
      bbhit4_ff <= bbhit3_ff;
   end

   // ---------------- stage 5: recombine wide products ----------------
   function automatic logic [XW-1:0] join_pp(input logic [2*LO-1:0] p0, input logic [2*LO-1:0] p1,
                                             input logic [2*LO-1:0] p2, input logic [2*LO-1:0] p3);
      logic [XW-1:0] r;
      r = XW'(p0) + (XW'(p1) << LO) + (XW'(p2) << LO) + (XW'(p3) << (2*LO));
      return r;
   endfunction

   logic [XW-1:0] fa5_ff, fr5_ff, ee5_ff;
   logic          v5_ff, is_bb5_ff, bbhit5_ff, near5_ff, far5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      fa5_ff <= join_pp(pfa4_ff[0], pfa4_ff[1], pfa4_ff[2], pfa4_ff[3]);
      fr5_ff <= join_pp(pfr4_ff[0], pfr4_ff[1], pfr4_ff[2], pfr4_ff[3]);
      ee5_ff <= join_pp(pee4_ff[0], pee4_ff[1], pee4_ff[2], pee4_ff[3]);
      near5_ff  <= near4_ff;
      far5_ff   <= far4_ff;
      is_bb5_ff <= is_bb4_ff;
      bbhit5_ff <= bbhit4_ff;
   end

   // ---------------- stage 6: final compare ----------------
   logic hit_in;

   always_comb begin
      if (is_bb5_ff)    hit_in = bbhit5_ff;
      else if (far5_ff) hit_in = ((XW+1)'(fa5_ff) <= (XW+1)'(fr5_ff) + (XW+1)'(ee5_ff));
      else              hit_in = near5_ff;
   end

   logic strobe_ff, hit_ff;

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= v5_ff;
      hit_ff <= hit_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_hit    = hit_ff;

endmodule

// ===== bench/spct_checker.sv =====
// Checker for the shape pair collision test: predicts each hit bit and compares results.
module spct_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_a_kind,
   input  logic                          req_b_kind,
   input  logic [1:0]                    req_swept_sel,
   input  logic [spct_pkg::POINT_W-1:0]  req_a_point,
   input  logic [spct_pkg::POINT_W-1:0]  req_a_corner,
   input  logic [spct_pkg::RADIUS_W-1:0] req_a_radius,
   input  logic [spct_pkg::POINT_W-1:0]  req_a_prev,
   input  logic [spct_pkg::POINT_W-1:0]  req_b_point,
   input  logic [spct_pkg::POINT_W-1:0]  req_b_corner,
   input  logic [spct_pkg::RADIUS_W-1:0] req_b_radius,
   input  logic [spct_pkg::POINT_W-1:0]  req_b_prev,
   input  logic                          rsp_strobe,
   input  logic                          rsp_hit,
   output int                            fail_count,
   output int                            pending_hits
);

   localparam int CB = spct_pkg::COORD_BITS_DEF;

   // two spare bits for differences
   typedef struct { logic signed [CB+1:0] v[3]; } vec_type;

   logic expected_hits[$];

   assign pending_hits = expected_hits.size();

   function automatic vec_type unpack_point(logic [spct_pkg::POINT_W-1:0] w);
      vec_type r;
      for (int i = 0; i < 3; i++) r.v[i] = $signed(w[i*CB +: CB]);
      return r;
   endfunction

   function automatic vec_type vsub(vec_type p, vec_type q);
      vec_type r;
      for (int i = 0; i < 3; i++) r.v[i] = p.v[i] - q.v[i];
      return r;
   endfunction

   function automatic logic signed [127:0] vdot(vec_type p, vec_type q);
      logic signed [127:0] s;
      s = 0;
      for (int i = 0; i < 3; i++) s += 128'(signed'(p.v[i])) * 128'(signed'(q.v[i]));
      return s;
   endfunction

   function automatic logic path_hit(vec_type s0, vec_type s1, vec_type c, logic [127:0] rsum);
      vec_type ab, ac, bc;
      logic signed [127:0] e, f, r2, acac;
      ab = vsub(s1, s0);
      ac = vsub(c, s0);
      r2 = rsum * rsum;
      e = vdot(ac, ab);
      acac = vdot(ac, ac);
      if (e <= 0) return acac <= r2;
      f = vdot(ab, ab);
      if (e >= f) begin
         bc = vsub(c, s1);
         return vdot(bc, bc) <= r2;
      end
      return f * acac <= f * r2 + e * e;
   endfunction

   function automatic logic box_overlap(vec_type amin, vec_type amax, vec_type bmin,
                                        vec_type bmax);
      for (int i = 0; i < 3; i++)
         if (amin.v[i] > bmax.v[i] || amax.v[i] < bmin.v[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic box_ball(vec_type bmin, vec_type bmax, vec_type c, logic [127:0] r);
      logic signed [127:0] d2, d;
      logic signed [CB+1:0] p;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
         p = c.v[i];
         if (p < bmin.v[i]) p = bmin.v[i];
         else if (p > bmax.v[i]) p = bmax.v[i];
         d = 128'(signed'(c.v[i])) - 128'(signed'(p));
         d2 += d * d;
      end
      return d2 <= $signed(r * r);
   endfunction

   function automatic logic predict_hit();
      vec_type ap, ac, apr, bp, bc, bpr, d;
      logic [127:0] ar, br;
      ap = unpack_point(req_a_point);
      ac = unpack_point(req_a_corner);
      apr = unpack_point(req_a_prev);
      bp = unpack_point(req_b_point);
      bc = unpack_point(req_b_corner);
      bpr = unpack_point(req_b_prev);
      ar = 128'(req_a_radius[CB-2:0]);
      br = 128'(req_b_radius[CB-2:0]);
      if (req_a_kind == spct_pkg::KIND_SPHERE && req_b_kind == spct_pkg::KIND_SPHERE) begin
         if (req_swept_sel[0]) return path_hit(apr, ap, bp, ar + br);
         if (req_swept_sel[1]) return path_hit(bpr, bp, ap, ar + br);
         d = vsub(ap, bp);
         return vdot(d, d) <= $signed((ar + br) * (ar + br));
      end
      if (req_a_kind == spct_pkg::KIND_BOX && req_b_kind == spct_pkg::KIND_BOX)
         return box_overlap(ap, ac, bp, bc);
      if (req_a_kind == spct_pkg::KIND_BOX) return box_ball(ap, ac, bp, br);
      return box_ball(bp, bc, ap, ar);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy) expected_hits = {expected_hits, predict_hit()};
         if (rsp_strobe) begin
            if (expected_hits.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected transaction: hit=%0b", rsp_hit);
            end else begin
               if (expected_hits[0] !== rsp_hit) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("hit mismatch: expected %0b actual %0b", expected_hits[0], rsp_hit);
               end
               void'(expected_hits.pop_front());
            end
         end
      end
   end
endmodule

// ===== bench/tb_shape_pair_collision_test.sv =====
// Testbench top: drives shape pairs into the collision test and reports the verdict.
module tb_shape_pair_collision_test;

   localparam int CB = spct_pkg::COORD_BITS_DEF;
   localparam int PTW = spct_pkg::POINT_W;
   localparam int RW = spct_pkg::RADIUS_W;
   localparam logic SPH = spct_pkg::KIND_SPHERE;
   localparam logic BOX = spct_pkg::KIND_BOX;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy, rsp_strobe, rsp_hit;
   logic req_a_kind = 0, req_b_kind = 0;
   logic [1:0] req_swept_sel = 0;
   logic [PTW-1:0] req_a_point = 0, req_a_corner = 0, req_a_prev = 0;
   logic [PTW-1:0] req_b_point = 0, req_b_corner = 0, req_b_prev = 0;
   logic [RW-1:0] req_a_radius = 0, req_b_radius = 0;
   int fail_count, pending_hits;
   int idle_pct;
   int quiet_cycles;

   always #5 clock = ~clock;

   shape_pair_collision_test DUT (.*);

   spct_checker checker_i (.*);

   // cycles with no accepted transaction on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [CB-1:0] rand_coord(int spread);
      case ($urandom_range(0, 9))
         0: return {1'b0, {(CB-1){1'b1}}};
         1: return {1'b1, {(CB-1){1'b0}}};
         2: return CB'($urandom);
         default: return CB'($signed($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   function automatic logic [PTW-1:0] near_point(int spread);
      return {rand_coord(spread), rand_coord(spread), rand_coord(spread)};
   endfunction

   function automatic logic [RW-1:0] rand_radius(int spread);
      if ($urandom_range(0, 3) == 0) return RW'($urandom);
      return RW'($urandom_range(0, spread));
   endfunction

   task automatic send_pair(logic ak, logic bk, logic [1:0] sw,
                            logic [PTW-1:0] ap, ac, apr, bp, bc, bpr,
                            logic [RW-1:0] ar, br);
      req_a_kind <= ak;  req_b_kind <= bk;  req_swept_sel <= sw;
      req_a_point <= ap; req_a_corner <= ac; req_a_prev <= apr; req_a_radius <= ar;
      req_b_point <= bp; req_b_corner <= bc; req_b_prev <= bpr; req_b_radius <= br;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_random(int spread);
      logic [PTW-1:0] ap, bp;
      ap = near_point(spread);
      bp = near_point(spread);
      if ($urandom_range(0, 9) == 0) begin
         ap = PTW'({$urandom, $urandom});
         bp = PTW'({$urandom, $urandom});
      end
      send_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                ap, near_point(spread), near_point(spread),
                bp, near_point(spread), near_point(spread),
                rand_radius(spread), rand_radius(spread));
   endtask

   logic [PTW-1:0] maxp, minp, zp, onep;

   initial begin
      maxp = {3{1'b0, {(CB-1){1'b1}}}};
      minp = {3{1'b1, {(CB-1){1'b0}}}};
      zp = '0;
      onep = {CB'(0), CB'(0), CB'(256)};
      idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // directed: kinds, sweep flags, extremes, degenerate boxes, stationary projectile
      send_pair(SPH, SPH, 2'd0, zp, zp, zp, onep, zp, zp, 20'd128, 20'd128);
      send_pair(SPH, SPH, 2'd0, zp, zp, zp, onep, zp, zp, 20'd127, 20'd128);
      send_pair(SPH, SPH, 2'd0, maxp, maxp, maxp, minp, minp, minp, '1, '1);
      send_pair(SPH, SPH, 2'd1, maxp, zp, minp, zp, zp, zp, 20'd1, 20'd1);
      send_pair(SPH, SPH, 2'd2, zp, zp, zp, maxp, zp, minp, 20'd1, 20'd1);
      send_pair(SPH, SPH, 2'd3, onep, zp, onep, zp, zp, zp, 20'd256, 20'd0);
      send_pair(SPH, SPH, 2'd1, minp, zp, maxp, maxp, zp, zp, '1, '1);
      send_pair(BOX, BOX, 2'd3, zp, onep, zp, onep, maxp, zp, 20'd0, 20'd0);
      send_pair(BOX, BOX, 2'd0, minp, maxp, zp, minp, maxp, zp, 20'd0, 20'd0);
      send_pair(BOX, BOX, 2'd0, onep, zp, zp, zp, onep, zp, 20'd0, 20'd0);
      send_pair(BOX, SPH, 2'd1, zp, onep, zp, maxp, zp, zp, '1, '1);
      send_pair(SPH, BOX, 2'd2, minp, zp, zp, zp, maxp, zp, '1, '0);
      send_pair(SPH, BOX, 2'd0, onep, zp, zp, onep, zp, zp, 20'd5, 20'd0);
      send_pair(BOX, SPH, 2'd0, maxp, minp, zp, zp, zp, zp, 20'd0, 20'd3);
      send_pair(SPH, SPH, 2'd0, '1, '1, '1, '1, '1, '1, '1, '1);
      start <= 1'b0;
      // hold off until the pipeline drains
      while (pending_hits != 0) @(posedge clock);
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 55 : (phase == 3) ? 22 : 0;
         for (int n = 0; n < 200; n++) send_random((n % 3 == 0) ? 4000 : 300);
      end
      start <= 1'b0;
      while (pending_hits != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
